FILE: src/sqae_pkg.sv
// Shared types and constants for the stack/queue add engine.
package sqae_pkg;

  // Default number of ring entries
  localparam int unsigned DEPTH_DEF = 256;

  // Payload widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned DEPTH_W = 9;
  localparam int unsigned STAT_W  = 2;

  // Fewest entries an add needs
  localparam int unsigned ADD_MIN_ENTRIES = 2;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_ADD    = 2'd2
  } func_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

FILE: src/stack_queue_add_engine.sv
// Double-ended stack of signed 32-bit values in a ring memory, with push, append and add.
// Each accepted item returns one result: the top value (zero when empty), the depth and a
// status. Push, append, an unused code and every rejected operation (full store, or add on
// fewer than two entries) are done in idle; an add enters ST_ADD, since the second entry is
// read from the single-port-read ring memory (registered read) before the sum is written
// back. The top entry is held in a register, so no other item touches the memory read port.
// A stalled result holds off the input; the next item can be taken in the same cycle that
// the result transfers. The ring needs no clearing after reset: only live entries are read.
module stack_queue_add_engine
  import sqae_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [DATA_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic [DEPTH_W-1:0]       out_depth,
  output logic [STAT_W-1:0]        out_status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] ADD_MIN  = CW'(ADD_MIN_ENTRIES);

  typedef enum logic {
    ST_IDLE,
    ST_ADD
  } state_t;

  // Registers
  state_t                     state_r, state_nxt;
  logic [AW-1:0]              tp_r, tp_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0]   top_r, top_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]   out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0]         out_depth_r, out_depth_nxt;
  logic [STAT_W-1:0]          out_status_r, out_status_nxt;

  // Ring memory
  logic signed [DATA_W-1:0]   mem [DEPTH];
  logic signed [DATA_W-1:0]   rd_data_r;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0]   mem_wdata;

  // Pointer arithmetic
  logic [AW-1:0]              tp_dec, tp_inc, tail_idx;
  logic [AW:0]                tail_sum;
  logic                       is_full, is_short, in_xfer;
  logic signed [DATA_W-1:0]   add_sum;

  assign in_stall = !((state_r == ST_IDLE) && !(out_valid_r && out_stall));
  assign in_xfer  = in_valid && !in_stall;

  assign tp_dec   = (tp_r == '0) ? LAST_IDX : tp_r - 1'b1;
  assign tp_inc   = (tp_r == LAST_IDX) ? '0 : tp_r + 1'b1;
  assign tail_sum = {1'b0, tp_r} + (AW+1)'(cnt_r);
  assign tail_idx = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
  assign is_full  = (cnt_r == DEPTH_C);
  assign is_short = (cnt_r < ADD_MIN);
  assign add_sum  = top_r + rd_data_r;

  // Next-state and memory control
  always_comb begin
    status_t st_v;
    logic    pend_add;
    state_nxt      = state_r;
    tp_nxt         = tp_r;
    cnt_nxt        = cnt_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = tp_dec;
    mem_raddr      = tp_inc;
    mem_wdata      = in_value;
    st_v           = STAT_OK;
    pend_add       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            FUNC_PUSH: begin
              if (is_full) begin
                st_v = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tp_dec;
                tp_nxt    = tp_dec;
                cnt_nxt   = cnt_r + 1'b1;
                top_nxt   = in_value;
              end
            end
            FUNC_APPEND: begin
              if (is_full) begin
                st_v = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_idx;
                cnt_nxt   = cnt_r + 1'b1;
                if (cnt_r == '0) begin
                  top_nxt = in_value;
                end
              end
            end
            FUNC_ADD: begin
              if (is_short) begin
                st_v = STAT_SHORT;
              end else begin
                // fetch the second entry, finish next cycle
                mem_re    = 1'b1;
                pend_add  = 1'b1;
                state_nxt = ST_ADD;
              end
            end
            default: ;
          endcase
          if (!pend_add) begin
            out_valid_nxt  = 1'b1;
            out_top_nxt    = (cnt_nxt != '0) ? top_nxt : '0;
            out_depth_nxt  = DEPTH_W'(cnt_nxt);
            out_status_nxt = st_v;
          end
        end
      end
      ST_ADD: begin
        // write the sum over the second entry, it becomes the top
        mem_we         = 1'b1;
        mem_waddr      = tp_inc;
        mem_wdata      = add_sum;
        tp_nxt         = tp_inc;
        cnt_nxt        = cnt_r - 1'b1;
        top_nxt        = add_sum;
        out_valid_nxt  = 1'b1;
        out_top_nxt    = add_sum;
        out_depth_nxt  = DEPTH_W'(cnt_r - 1'b1);
        out_status_nxt = STAT_OK;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tp_r        <= tp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  // Ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;

`ifndef SYNTH
  // The live count never exceeds the ring size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above ring size");

  // No item is taken while an add is finishing
  a_add_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD |-> in_stall)
    else $error("input accepted during add write-back");

  // An add always yields a result in the following cycle
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD |=> out_valid && out_status == STAT_OK && state_r == ST_IDLE)
    else $error("add did not complete");

  // An empty store reports a zero top
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == '0 && state_r == ST_IDLE |-> out_top_value == '0)
    else $error("nonzero top on empty store");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for stack_queue_add_engine: push, append and add on a ring-based deque.
`timescale 1ns / 1ps

module testbench;
  import sqae_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  // func code the block leaves unused; must act as a no-op
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_PRINTS = 100;

  // One result transfer as the block should produce it
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    status_t                  status;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] in_func;
  logic signed [DATA_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_top_value;
  logic [DEPTH_W-1:0] out_depth;
  logic [STAT_W-1:0] out_status;

  // Shadow copy of the deque
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  int unsigned ring_top = 0;
  int unsigned ring_count = 0;

  stack_result_t expected_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_idx = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles_left = 0;

  stack_queue_add_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_status    (out_status)
  );

  always #2 clk = ~clk;

  // Apply one operation to the shadow deque and return the result it yields
  function automatic stack_result_t apply_stack_op(input logic [FUNC_W-1:0] func,
                                                   input logic [DATA_W-1:0] value);
    stack_result_t res;
    int unsigned below;
    res.status = STAT_OK;
    case (func)
      FUNC_PUSH: begin
        if (ring_count >= RING_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          ring_top = (ring_top + RING_DEPTH - 1) % RING_DEPTH;
          ring_mem[ring_top] = value;
          ring_count++;
        end
      end
      FUNC_APPEND: begin
        if (ring_count >= RING_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          ring_mem[(ring_top + ring_count) % RING_DEPTH] = value;
          ring_count++;
        end
      end
      FUNC_ADD: begin
        if (ring_count < ADD_MIN_ENTRIES) begin
          res.status = STAT_SHORT;
        end else begin
          below = (ring_top + 1) % RING_DEPTH;
          ring_mem[below] = ring_mem[ring_top] + ring_mem[below];
          ring_top = below;
          ring_count--;
        end
      end
      default: ;
    endcase
    res.top_value = (ring_count != 0) ? ring_mem[ring_top] : '0;
    res.depth = DEPTH_W'(ring_count);
    return res;
  endfunction

  // Random value, biased toward the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return DATA_W'($urandom_range(0, 3));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Random operation; add_pct sets the share of adds
  function automatic logic [FUNC_W-1:0] pick_func(input int unsigned add_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return FUNC_UNUSED;
    if (roll < 4 + add_pct) return FUNC_ADD;
    return $urandom_range(0, 1) ? FUNC_PUSH : FUNC_APPEND;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("ERROR @%0t result %0d: %s", $realtime,
                                              result_idx, msg);
    mismatch_count++;
  endtask

  // Offer one item in bursts with random gaps; predict once the transfer happens
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(apply_stack_op(func, value));
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Extremes, wraparound sums, short adds and the unused code
  task automatic test_directed();
    send_op(FUNC_ADD, '0);
    send_op(FUNC_UNUSED, 32'h1234_5678);
    send_op(FUNC_PUSH, 32'h7FFF_FFFF);
    send_op(FUNC_ADD, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH, 32'h0000_0001);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_APPEND, 32'h8000_0000);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_PUSH, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH, 32'hFFFF_FFFF);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_APPEND, '0);
    send_op(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_op(FUNC_APPEND, 32'h5555_5555);
    send_op(FUNC_PUSH, 32'hAAAA_AAAA);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_ADD, '0);
    send_op(FUNC_PUSH, 32'h8000_0000);
    send_op(FUNC_ADD, '0);
  endtask

  // Random mix of all codes at moderate depth
  task automatic test_random_mix(input int unsigned n_items);
    repeat (n_items) send_op(pick_func(40), pick_value());
  endtask

  // Fill to capacity, bounce off the full store, then fold back down with adds
  task automatic test_fill_and_fold();
    logic [FUNC_W-1:0] func;
    while (ring_count < RING_DEPTH)
      send_op($urandom_range(0, 1) ? FUNC_PUSH : FUNC_APPEND, pick_value());
    repeat (8) send_op($urandom_range(0, 1) ? FUNC_PUSH : FUNC_APPEND, pick_value());
    send_op(FUNC_UNUSED, pick_value());
    while (ring_count > 1) begin
      func = pick_func(88);
      send_op(func, pick_value());
    end
    send_op(FUNC_ADD, pick_value());
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold();
    hold_cycles_left = HOLD_CYCLES;
    repeat (40) send_op(pick_func(30), pick_value());
  endtask

  // Receiver stall pattern: segments of random stall density, plus requested hold-offs
  initial begin : result_stall_gen
    int unsigned seg_left;
    int unsigned stall_pct;
    seg_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_left > 0) begin
        out_stall <= 1'b1;
        hold_cycles_left--;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    stack_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (out_top_value !== want.top_value)
          report_mismatch($sformatf("top_value got %0d want %0d", out_top_value,
                                    want.top_value));
        if (out_depth !== want.depth)
          report_mismatch($sformatf("depth got %0d want %0d", out_depth, want.depth));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %s", out_status, want.status.name()));
      end
      result_idx++;
    end
  end

  initial begin : main_seq
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_PUSH;
    in_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_results_drained();
    test_random_mix(100);
    wait_results_drained();
    test_fill_and_fold();
    wait_results_drained();
    test_output_hold();
    wait_results_drained();
    test_random_mix(50);
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stack_queue_add_engine: match");
    end else begin
      $display("stack_queue_add_engine: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin : watchdog
    #(2_000_000);
    $display("stack_queue_add_engine: mismatch");
    $finish;
  end

endmodule

FILE: files.f
src/sqae_pkg.sv
src/stack_queue_add_engine.sv
tb/testbench.sv
